// File: design/imusbd_pkg.sv
// Shared types, constants and saturation helpers for the IMU smoother.
package imusbd_pkg;

    localparam int unsigned NumCh = 6;

    // configuration register indexes
    localparam logic [1:0] CFG_ACCEL_FS  = 2'd0;
    localparam logic [1:0] CFG_GYRO_FS   = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;

    localparam logic [4:0]  ACCEL_FS_RST  = 5'd16;
    localparam logic [10:0] GYRO_FS_RST   = 11'd250;
    localparam logic [30:0] THRESHOLD_RST = 31'd8586527;

    // coefficient: k = (min(el, 1e6) * 2^16 + 5e5) / 1e6 = floor((el * 1024 + 7812) / 15625),
    // the division done as a multiply by ceil(2^44 / 15625), exact for numerators below 2^30
    localparam logic [19:0] ELAPSED_MAX = 20'd1000000;
    localparam logic [29:0] K_ROUND_Q10 = 30'd7812;
    localparam logic [30:0] K_RECIP     = 31'd1125899907;
    localparam int unsigned KShift      = 44;
    localparam int unsigned KBits       = 17;

    // 9.81 in Q16.16, truncated
    localparam logic signed [20:0] GRAVITY_Q16 = 21'sd642908;
    localparam logic signed [28:0] ONE_Q16     = 29'sd65536;

    localparam logic signed [55:0] W_MAX = 56'sd2147483647;
    localparam logic signed [55:0] W_MIN = -56'sd2147483648;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_UPD,
        S_WAIT
    } t_state;

    // step strobes sent to every lane
    typedef struct packed {
        logic ld;
        logic pre;
        logic mul;
        logic upd;
        logic commit;
    } t_lane_ctl;

    function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
        logic signed [31:0] r;
        if (v > W_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < W_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [20:0] sat_out21(input logic signed [31:0] v);
        logic signed [20:0] r;
        if (v > 32'sd1048575) begin
            r = 21'sd1048575;
        end else if (v < -32'sd1048576) begin
            r = -21'sd1048576;
        end else begin
            r = v[20:0];
        end
        return r;
    endfunction

    function automatic logic signed [27:0] sat_out28(input logic signed [31:0] v);
        logic signed [27:0] r;
        if (v > 32'sd134217727) begin
            r = 28'sd134217727;
        end else if (v < -32'sd134217728) begin
            r = -28'sd134217728;
        end else begin
            r = v[27:0];
        end
        return r;
    endfunction

endpackage

// File: design/imusbd_kdiv.sv
// Filter coefficient from elapsed time by reciprocal multiplication.
module imusbd_kdiv (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [19:0]                      i_elapsed_us,
    output logic                             o_done,
    output logic [imusbd_pkg::KBits-1:0]     o_k
);

    logic        r_busy;
    logic [29:0] r_num;
    logic [imusbd_pkg::KBits-1:0] r_k;

    logic [19:0] w_el;
    logic [29:0] w_num;
    logic [60:0] w_prod;

    always_comb begin
        w_el   = (i_elapsed_us > imusbd_pkg::ELAPSED_MAX) ? imusbd_pkg::ELAPSED_MAX
                                                           : i_elapsed_us;
        w_num  = {w_el, 10'd0} + imusbd_pkg::K_ROUND_Q10;
        w_prod = r_num * imusbd_pkg::K_RECIP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_start;
        end
        if (i_start) begin
            r_num <= w_num;
        end
        if (r_busy) begin
            r_k <= w_prod[imusbd_pkg::KShift+imusbd_pkg::KBits-1:imusbd_pkg::KShift];
        end
    end

    // quotient is registered at the end of the busy cycle
    assign o_done = r_busy;
    assign o_k    = r_k;

endmodule

// File: design/imusbd_lane.sv
// One low-pass filter lane: scale, weighted difference, saturating state update.
module imusbd_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  imusbd_pkg::t_lane_ctl         i_ctl,
    input  logic signed [15:0]            i_raw,
    input  logic [10:0]                   i_range,
    input  logic [imusbd_pkg::KBits-1:0]  i_k,
    output logic signed [27:0]            o_x,
    output logic signed [31:0]            o_new
);

    logic signed [27:0] r_x;
    logic signed [50:0] r_prod;
    logic signed [31:0] r_new;
    logic signed [31:0] r_s;

    logic signed [27:0] w_xr;
    logic signed [32:0] w_diff;
    logic signed [50:0] w_sh;
    logic signed [55:0] w_sum;

    always_comb begin
        w_xr   = i_raw * $signed({1'b0, i_range});
        w_diff = $signed({{5{r_x[27]}}, r_x}) - $signed({r_s[31], r_s});
        w_sh   = r_prod >>> 16;
        w_sum  = $signed({{5{w_sh[50]}}, w_sh}) + $signed({{24{r_s[31]}}, r_s});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= '0;
        end else if (i_ctl.commit) begin
            r_s <= r_new;
        end
        if (i_ctl.ld) begin
            r_x <= w_xr <<< 1;
        end
        if (i_ctl.mul) begin
            r_prod <= $signed({1'b0, i_k}) * w_diff;
        end
        if (i_ctl.upd) begin
            r_new <= imusbd_pkg::sat32(w_sum);
        end
    end

    assign o_x   = r_x;
    assign o_new = r_new;

endmodule

// File: design/imusbd_vel.sv
// Velocity integrator on unfiltered X acceleration, with the latching burnout flag.
module imusbd_vel (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  imusbd_pkg::t_lane_ctl         i_ctl,
    input  logic signed [27:0]            i_x0,
    input  logic [imusbd_pkg::KBits-1:0]  i_k,
    input  logic [30:0]                   i_threshold,
    output logic                          o_flag
);

    logic signed [49:0] r_ap;
    logic signed [51:0] r_ak;
    logic signed [31:0] r_vnew;
    logic               r_hit;
    logic signed [31:0] r_v;
    logic               r_lat;

    logic signed [28:0] w_xa;
    logic signed [33:0] w_a;
    logic signed [35:0] w_sh;
    logic signed [55:0] w_sum;
    logic signed [31:0] w_vsat;

    always_comb begin
        w_xa   = $signed({i_x0[27], i_x0}) + imusbd_pkg::ONE_Q16;
        w_a    = r_ap[49:16];
        w_sh   = r_ak[51:16];
        w_sum  = $signed({{20{w_sh[35]}}, w_sh}) + $signed({{24{r_v[31]}}, r_v});
        w_vsat = imusbd_pkg::sat32(w_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
            r_lat <= 1'b0;
        end else if (i_ctl.commit && !r_lat) begin
            r_v <= r_vnew;
            if (r_hit) begin
                r_lat <= 1'b1;
            end
        end
        if (i_ctl.pre) begin
            r_ap <= w_xa * imusbd_pkg::GRAVITY_Q16;
        end
        if (i_ctl.mul) begin
            r_ak <= w_a * $signed({1'b0, i_k});
        end
        if (i_ctl.upd) begin
            r_vnew <= w_vsat;
            r_hit  <= (w_vsat >= $signed({1'b0, i_threshold}));
        end
    end

    // flag as it stands after this item's commit
    assign o_flag = r_lat | r_hit;

endmodule

// File: design/imu_smoother_burnout_detect.sv
// IMU smoother: six filter lanes, velocity integrator, sequencer and output merge.
// An accepted item passes through coefficient, weighted difference, state update and
//   commit, one item in flight at a time; a new item is taken only after the commit.
// Reset (synchronous, active low): filter states, velocity sum and flag cleared,
//   registers back to their defaults; items are taken from the next cycle.
module imu_smoother_burnout_detect (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [15:0]  i_accel_x_raw,
    input  logic signed [15:0]  i_accel_y_raw,
    input  logic signed [15:0]  i_accel_z_raw,
    input  logic signed [15:0]  i_gyro_x_raw,
    input  logic signed [15:0]  i_gyro_y_raw,
    input  logic signed [15:0]  i_gyro_z_raw,
    input  logic [19:0]         i_elapsed_us,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [20:0]  o_accel_x_smooth,
    output logic signed [20:0]  o_accel_y_smooth,
    output logic signed [20:0]  o_accel_z_smooth,
    output logic signed [27:0]  o_gyro_x_smooth,
    output logic signed [27:0]  o_gyro_y_smooth,
    output logic signed [27:0]  o_gyro_z_smooth,
    output logic                o_burnout_flag,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [30:0]         i_cfg_data
);

    imusbd_pkg::t_state    r_state, n_state;
    imusbd_pkg::t_lane_ctl w_ctl;

    logic [4:0]  r_accel_fs;
    logic [10:0] r_gyro_fs;
    logic [30:0] r_threshold;

    logic        r_out_valid;
    logic signed [20:0] r_ax, r_ay, r_az;
    logic signed [27:0] r_gx, r_gy, r_gz;
    logic        r_flag;

    logic        w_accept;
    logic        w_div_done;
    logic        w_flag;
    logic [imusbd_pkg::KBits-1:0] w_k;

    logic signed [15:0] w_raw   [imusbd_pkg::NumCh];
    logic [10:0]        w_range [imusbd_pkg::NumCh];
    logic signed [27:0] w_x     [imusbd_pkg::NumCh];
    logic signed [31:0] w_new   [imusbd_pkg::NumCh];

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != imusbd_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_raw[0] = i_accel_x_raw;
        w_raw[1] = i_accel_y_raw;
        w_raw[2] = i_accel_z_raw;
        w_raw[3] = i_gyro_x_raw;
        w_raw[4] = i_gyro_y_raw;
        w_raw[5] = i_gyro_z_raw;
        w_range[0] = {6'd0, r_accel_fs};
        w_range[1] = {6'd0, r_accel_fs};
        w_range[2] = {6'd0, r_accel_fs};
        w_range[3] = r_gyro_fs;
        w_range[4] = r_gyro_fs;
        w_range[5] = r_gyro_fs;
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        w_ctl.ld     = 1'b0;
        w_ctl.pre    = 1'b0;
        w_ctl.mul    = 1'b0;
        w_ctl.upd    = 1'b0;
        w_ctl.commit = 1'b0;
        case (r_state)
            imusbd_pkg::S_IDLE: begin
                if (w_accept) begin
                    w_ctl.ld = 1'b1;
                    n_state  = imusbd_pkg::S_DIV;
                end
            end
            imusbd_pkg::S_DIV: begin
                w_ctl.pre = 1'b1;
                if (w_div_done) begin
                    n_state = imusbd_pkg::S_MUL;
                end
            end
            imusbd_pkg::S_MUL: begin
                w_ctl.mul = 1'b1;
                n_state   = imusbd_pkg::S_UPD;
            end
            imusbd_pkg::S_UPD: begin
                w_ctl.upd = 1'b1;
                n_state   = imusbd_pkg::S_WAIT;
            end
            imusbd_pkg::S_WAIT: begin
                // commit state only when the output register can take the item
                if (!r_out_valid || !i_out_stall) begin
                    w_ctl.commit = 1'b1;
                    n_state      = imusbd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = imusbd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= imusbd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_fs  <= imusbd_pkg::ACCEL_FS_RST;
            r_gyro_fs   <= imusbd_pkg::GYRO_FS_RST;
            r_threshold <= imusbd_pkg::THRESHOLD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                imusbd_pkg::CFG_ACCEL_FS:  r_accel_fs  <= i_cfg_data[4:0];
                imusbd_pkg::CFG_GYRO_FS:   r_gyro_fs   <= i_cfg_data[10:0];
                imusbd_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    imusbd_kdiv u_kdiv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_ctl.ld),
        .i_elapsed_us (i_elapsed_us),
        .o_done       (w_div_done),
        .o_k          (w_k)
    );

    for (genvar g = 0; g < imusbd_pkg::NumCh; g++) begin : g_lane
        imusbd_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_raw   (w_raw[g]),
            .i_range (w_range[g]),
            .i_k     (w_k),
            .o_x     (w_x[g]),
            .o_new   (w_new[g])
        );
    end

    imusbd_vel u_vel (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_x0        (w_x[0]),
        .i_k         (w_k),
        .i_threshold (r_threshold),
        .o_flag      (w_flag)
    );

    // merge lane results into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_ctl.commit) begin
            r_ax   <= imusbd_pkg::sat_out21(w_new[0]);
            r_ay   <= imusbd_pkg::sat_out21(w_new[1]);
            r_az   <= imusbd_pkg::sat_out21(w_new[2]);
            r_gx   <= imusbd_pkg::sat_out28(w_new[3]);
            r_gy   <= imusbd_pkg::sat_out28(w_new[4]);
            r_gz   <= imusbd_pkg::sat_out28(w_new[5]);
            r_flag <= w_flag;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_accel_x_smooth = r_ax;
    assign o_accel_y_smooth = r_ay;
    assign o_accel_z_smooth = r_az;
    assign o_gyro_x_smooth  = r_gx;
    assign o_gyro_y_smooth  = r_gy;
    assign o_gyro_z_smooth  = r_gz;
    assign o_burnout_flag   = r_flag;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the IMU smoother with burnout detection.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  CFG_SPARE     = 2'd3;   // no register behind it
    localparam logic [30:0] THRESHOLD_TOP = 31'h7FFF_FFFF;
    localparam int          DrainCycles   = 25;

    typedef struct packed {
        logic [5:0][15:0] raw;          // ax, ay, az, gx, gy, gz
        logic [19:0]      elapsed_us;
    } t_sample;

    typedef struct packed {
        logic [2:0][20:0] accel;
        logic [2:0][27:0] gyro;
        logic             flag;
    } t_smooth;

    class smoother_ledger;
        longint  accel_range;
        longint  gyro_range;
        longint  threshold;
        longint  chan [imusbd_pkg::NumCh];
        longint  velocity;
        bit      latched;
        t_smooth expected_smooth [$];
        int      mismatches;

        function new();
            accel_range = imusbd_pkg::ACCEL_FS_RST;
            gyro_range  = imusbd_pkg::GYRO_FS_RST;
            threshold   = imusbd_pkg::THRESHOLD_RST;
            foreach (chan[i]) chan[i] = 0;
            velocity    = 0;
            latched     = 1'b0;
            mismatches  = 0;
        endfunction

        static function longint clamp(longint v, int w);
            longint top;
            top = (longint'(1) << (w - 1)) - 1;
            if (v > top) return top;
            if (v < -top - 1) return -top - 1;
            return v;
        endfunction

        function void write_reg(logic [1:0] idx, logic [30:0] value);
            case (idx)
                imusbd_pkg::CFG_ACCEL_FS:  accel_range = value[4:0];
                imusbd_pkg::CFG_GYRO_FS:   gyro_range  = value[10:0];
                imusbd_pkg::CFG_THRESHOLD: threshold   = value;
                default: ;
            endcase
        endfunction

        function void note_sample(t_sample smp);
            longint  el;
            longint  k;
            longint  a;
            longint  x [imusbd_pkg::NumCh];
            t_smooth r;
            el = smp.elapsed_us;
            if (el > imusbd_pkg::ELAPSED_MAX) el = imusbd_pkg::ELAPSED_MAX;
            // Q1.16 coefficient, rounded to nearest
            k = (el * 65536 + 500000) / 1000000;
            for (int i = 0; i < imusbd_pkg::NumCh; i++)
                x[i] = longint'($signed(smp.raw[i])) * (i < 3 ? accel_range : gyro_range) * 2;
            for (int i = 0; i < imusbd_pkg::NumCh; i++)
                chan[i] = clamp(chan[i] + ((k * (x[i] - chan[i])) >>> 16), 32);
            if (!latched) begin
                a = ((x[0] + longint'(imusbd_pkg::ONE_Q16))
                     * longint'(imusbd_pkg::GRAVITY_Q16)) >>> 16;
                velocity = clamp(velocity + ((a * k) >>> 16), 32);
                if (velocity >= threshold) latched = 1'b1;
            end
            for (int i = 0; i < 3; i++) begin
                r.accel[i] = 21'(clamp(chan[i], 21));
                r.gyro[i]  = 28'(clamp(chan[i + 3], 28));
            end
            r.flag = latched;
            expected_smooth.push_back(r);
        endfunction

        task flag_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_smooth(t_smooth got);
            t_smooth want;
            if (expected_smooth.size() == 0) begin
                flag_mismatch("result with nothing outstanding");
                return;
            end
            want = expected_smooth.pop_front();
            for (int i = 0; i < 3; i++) begin
                if (got.accel[i] !== want.accel[i])
                    flag_mismatch($sformatf("accel %0d: got %0d, want %0d", i,
                                  $signed(got.accel[i]), $signed(want.accel[i])));
                if (got.gyro[i] !== want.gyro[i])
                    flag_mismatch($sformatf("gyro %0d: got %0d, want %0d", i,
                                  $signed(got.gyro[i]), $signed(want.gyro[i])));
            end
            if (got.flag !== want.flag)
                flag_mismatch($sformatf("burnout flag: got %b, want %b", got.flag, want.flag));
        endtask
    endclass

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    t_sample       in_sample;
    logic          out_valid;
    logic          out_stall;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [1:0]    cfg_index;
    logic [30:0]   cfg_data;
    logic [2:0][20:0] accel_smooth;
    logic [2:0][27:0] gyro_smooth;
    logic          burnout_flag;

    int            in_idle_pct;
    int            out_stall_pct;
    smoother_ledger ledger;

    imu_smoother_burnout_detect u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_accel_x_raw    (in_sample.raw[0]),
        .i_accel_y_raw    (in_sample.raw[1]),
        .i_accel_z_raw    (in_sample.raw[2]),
        .i_gyro_x_raw     (in_sample.raw[3]),
        .i_gyro_y_raw     (in_sample.raw[4]),
        .i_gyro_z_raw     (in_sample.raw[5]),
        .i_elapsed_us     (in_sample.elapsed_us),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_accel_x_smooth (accel_smooth[0]),
        .o_accel_y_smooth (accel_smooth[1]),
        .o_accel_z_smooth (accel_smooth[2]),
        .o_gyro_x_smooth  (gyro_smooth[0]),
        .o_gyro_y_smooth  (gyro_smooth[1]),
        .o_gyro_z_smooth  (gyro_smooth[2]),
        .o_burnout_flag   (burnout_flag),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("imu_smoother_burnout_detect regression: fail");
        $finish;
    end

    // receiver back-pressure, redrawn every cycle
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            out_stall = ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge clk) begin : take_result
        t_smooth got;
        if (rst_n === 1'b1 && out_valid && !out_stall) begin
            got.accel = accel_smooth;
            got.gyro  = gyro_smooth;
            got.flag  = burnout_flag;
            ledger.check_smooth(got);
        end
    end

    function automatic t_sample pack_sample(int ax, int ay, int az, int gx, int gy, int gz,
                                            int el);
        t_sample smp;
        smp.raw[0] = ax[15:0];
        smp.raw[1] = ay[15:0];
        smp.raw[2] = az[15:0];
        smp.raw[3] = gx[15:0];
        smp.raw[4] = gy[15:0];
        smp.raw[5] = gz[15:0];
        smp.elapsed_us = el[19:0];
        return smp;
    endfunction

    function automatic t_sample rand_sample();
        t_sample smp;
        for (int i = 0; i < imusbd_pkg::NumCh; i++) begin
            case ($urandom_range(7))
                0: smp.raw[i] = 16'h8000;
                1: smp.raw[i] = 16'h7FFF;
                2: smp.raw[i] = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
                default: smp.raw[i] = 16'($urandom);
            endcase
        end
        case ($urandom_range(3))
            0: smp.elapsed_us = 20'($urandom_range(40));
            1: smp.elapsed_us = 20'($urandom_range(999_999));
            2: smp.elapsed_us = 20'($urandom_range(1_000_010, 999_990));
            default: smp.elapsed_us = 20'($urandom_range(20'hF_FFFF, 1_000_000));
        endcase
        return smp;
    endfunction

    // called and left at a falling edge; valid stays high across back-to-back items
    task automatic send_sample(t_sample smp);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        in_sample = smp;
        do @(posedge clk); while (in_stall);
        ledger.note_sample(smp);
        @(negedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [30:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        ledger.write_reg(idx, value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic settle();
        in_valid = 1'b0;
        while (ledger.expected_smooth.size() != 0) @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    task automatic run_random(int count);
        repeat (count) send_sample(rand_sample());
    endtask

    // full-scale X acceleration over long intervals: walks the velocity sum to a rail
    task automatic push_burst(logic [15:0] ax, int cap, bit stop_on_latch);
        t_sample smp;
        int      n;
        n = 0;
        while (n < cap && !(stop_on_latch && ledger.latched)) begin
            smp = rand_sample();
            smp.raw[0] = ax;
            smp.elapsed_us = 20'($urandom_range(20'hF_FFFF, 1_000_000));
            send_sample(smp);
            n++;
        end
    endtask

    initial begin
        ledger        = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_sample     = '0;
        cfg_valid     = 1'b0;
        cfg_index     = imusbd_pkg::CFG_ACCEL_FS;
        cfg_data      = '0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed items at reset settings; sum stays well under the default threshold
        send_sample(pack_sample(0, 0, 0, 0, 0, 0, 0));
        send_sample(pack_sample(-32768, 32767, -32768, 32767, -32768, 32767, 1048575));
        send_sample(pack_sample(32767, -32768, 32767, -32768, 32767, -32768, 1000000));
        send_sample(pack_sample(-32768, -1, 0, -1, 0, -1, 1000001));
        send_sample(pack_sample(-1, -1, -1, -1, -1, -1, 7));      // rounds to k = 0
        send_sample(pack_sample(1, 1, 1, 1, 1, 1, 8));           // rounds to k = 1
        send_sample(pack_sample(-32768, 32767, 32767, -32768, -32768, 32767, 999999));
        send_sample(pack_sample(12345, -12345, 23456, -23456, 54, -54, 500000));
        send_sample(pack_sample(0, 32767, -32768, 32767, -32768, 0, 1));
        send_sample(pack_sample(-32768, 0, 0, 0, 0, 0, 15));
        settle();

        write_cfg(imusbd_pkg::CFG_THRESHOLD, THRESHOLD_TOP);
        write_cfg(imusbd_pkg::CFG_ACCEL_FS, 31'd2);
        write_cfg(imusbd_pkg::CFG_GYRO_FS, 31'd125);
        send_sample(pack_sample(32767, 32767, 32767, 32767, 32767, 32767, 1000000));
        send_sample(pack_sample(-32768, -32768, -32768, -32768, -32768, -32768, 250000));
        in_idle_pct = 80;
        run_random(250);
        settle();

        // widest ranges; accel output saturates, velocity sum driven to its lower rail
        write_cfg(imusbd_pkg::CFG_ACCEL_FS, 31'd31);
        write_cfg(imusbd_pkg::CFG_GYRO_FS, 31'd2047);
        in_idle_pct   = 0;
        out_stall_pct = 80;
        push_burst(16'h8000, 130, 1'b0);
        run_random(200);
        settle();

        // zero ranges give zero samples; write to the spare index must be ignored
        write_cfg(imusbd_pkg::CFG_ACCEL_FS, 31'd0);
        write_cfg(imusbd_pkg::CFG_GYRO_FS, 31'd0);
        write_cfg(CFG_SPARE, 31'h7FFF_FFFF);
        in_idle_pct   = 11;
        out_stall_pct = 11;
        run_random(150);
        settle();

        write_cfg(imusbd_pkg::CFG_ACCEL_FS, 31'($urandom_range(30, 3)));
        write_cfg(imusbd_pkg::CFG_GYRO_FS, 31'($urandom_range(1999, 126)));
        in_idle_pct   = 80;
        out_stall_pct = 0;
        run_random(250);
        settle();

        // sum climbs to the upper rail, equal to the top threshold, and latches
        write_cfg(imusbd_pkg::CFG_ACCEL_FS, 31'd31);
        write_cfg(imusbd_pkg::CFG_GYRO_FS, 31'd2047);
        in_idle_pct   = 11;
        out_stall_pct = 11;
        push_burst(16'h7FFF, 300, 1'b1);
        run_random(50);
        settle();

        // flag must hold through a threshold rewrite
        write_cfg(imusbd_pkg::CFG_THRESHOLD, 31'd0);
        write_cfg(imusbd_pkg::CFG_ACCEL_FS, 31'(imusbd_pkg::ACCEL_FS_RST));
        write_cfg(imusbd_pkg::CFG_GYRO_FS, 31'(imusbd_pkg::GYRO_FS_RST));
        in_idle_pct   = 0;
        out_stall_pct = 80;
        run_random(200);
        settle();

        if (ledger.mismatches == 0) begin
            $display("imu_smoother_burnout_detect regression: pass");
        end else begin
            $display("imu_smoother_burnout_detect regression: fail");
        end
        $finish;
    end

endmodule

// File: imu_smoother_burnout_detect.f
design/imusbd_pkg.sv
design/imusbd_kdiv.sv
design/imusbd_lane.sv
design/imusbd_vel.sv
design/imu_smoother_burnout_detect.sv
tb/testbench.sv
